/* hw/rtl/ffsa_pkg.sv */
// Shared constants, payload structs and memory access types for the
// first-fit slot allocator. No dependencies.
`default_nettype none

package ffsa_pkg;

   localparam int ROWS          = 5;
   localparam int SLOTS_PER_ROW = 20;
   localparam int TOTAL_SLOTS   = ROWS * SLOTS_PER_ROW;
   localparam int TAG_BITS      = 42;
   localparam int LEN_W         = 5;
   localparam int ROW_W         = 3;
   localparam int SLOT_W        = 5;
   localparam int FREE_W        = 7;
   localparam int ADDR_W        = $clog2(TOTAL_SLOTS);

   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS_PER_ROW - 1);
   localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(SLOTS_PER_ROW);
   localparam logic [FREE_W-1:0] FREE_RESET = FREE_W'(TOTAL_SLOTS);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(TOTAL_SLOTS - 1);

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [TAG_BITS-1:0] vehicle_tag;
      logic [LEN_W-1:0]    vehicle_size;
   } ffsa_req_type;

   typedef struct packed {
      logic              ok;
      logic [ROW_W-1:0]  floor_index;
      logic [SLOT_W-1:0] slot_index;
      logic [FREE_W-1:0] free_slots;
   } ffsa_rsp_type;

   // owner tag and run length of one slot
   typedef struct packed {
      logic [TAG_BITS-1:0] owner;
      logic [LEN_W-1:0]    run_len;
   } ffsa_entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      ffsa_entry_type    wdata;
   } ffsa_ram_req_type;

endpackage

`default_nettype wire

/* hw/rtl/ffsa_slot_ram.sv */
// Slot entry memory: owner tag and run length per slot, one write or read
// per cycle, registered read data. Uses ffsa_pkg.
`default_nettype none

module ffsa_slot_ram (
   input  wire logic                      clock,
   input  wire ffsa_pkg::ffsa_ram_req_type ram_req,
   output      ffsa_pkg::ffsa_entry_type   rdata
);

   ffsa_pkg::ffsa_entry_type mem [ffsa_pkg::TOTAL_SLOTS];
   ffsa_pkg::ffsa_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      rdata_ff <= mem[ram_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/ffsa_scan_ctrl.sv */
// Request sequencer: used flags, free count and the scan over the slot
// memory for allocate and release. Uses ffsa_pkg and drives ffsa_slot_ram.
`default_nettype none

module ffsa_scan_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire ffsa_pkg::ffsa_req_type     req_data,
   output      ffsa_pkg::ffsa_ram_req_type ram_req,
   input  wire ffsa_pkg::ffsa_entry_type   ram_rdata,
   output      logic                       res_valid,
   input  wire logic                       res_ready,
   output      ffsa_pkg::ffsa_rsp_type     res_data
);

   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_ALLOC_SCAN  = 3'd1;
   localparam logic [2:0] ST_ALLOC_WRITE = 3'd2;
   localparam logic [2:0] ST_REL_SCAN    = 3'd3;
   localparam logic [2:0] ST_REL_FREE    = 3'd4;
   localparam logic [2:0] ST_FINISH      = 3'd5;

   // control state
   logic [2:0]                         state_ff, state_in;
   logic [ffsa_pkg::TOTAL_SLOTS-1:0]   used_ff, used_in;
   logic [ffsa_pkg::FREE_W-1:0]        free_ff, free_in;
   logic                               issue_ff, issue_in;
   logic                               rd_vld_ff, rd_vld_in;

   // working registers
   logic [ffsa_pkg::TAG_BITS-1:0]      tag_ff, tag_in;
   logic [ffsa_pkg::LEN_W-1:0]         len_ff, len_in;
   logic [ffsa_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic [ffsa_pkg::ROW_W-1:0]         row_ff, row_in;
   logic [ffsa_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [ffsa_pkg::LEN_W-1:0]         run_ff, run_in;
   logic                               rd_used_ff, rd_used_in;
   logic [ffsa_pkg::ADDR_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [ffsa_pkg::ROW_W-1:0]         rd_row_ff, rd_row_in;
   logic [ffsa_pkg::SLOT_W-1:0]        rd_slot_ff, rd_slot_in;
   logic                               ok_ff, ok_in;
   logic [ffsa_pkg::ROW_W-1:0]         res_row_ff, res_row_in;
   logic [ffsa_pkg::SLOT_W-1:0]        res_slot_ff, res_slot_in;

   logic                               cur_used;
   logic [ffsa_pkg::LEN_W-1:0]         run_nxt;
   logic                               rel_hit;

   assign cur_used = used_ff[addr_ff];
   assign run_nxt  = cur_used ? '0 : run_ff + ffsa_pkg::LEN_W'(1);
   assign rel_hit  = rd_vld_ff && rd_used_ff && (ram_rdata.owner == tag_ff);

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      free_in     = free_ff;
      issue_in    = issue_ff;
      rd_vld_in   = 1'b0;
      tag_in      = tag_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      row_in      = row_ff;
      slot_in     = slot_ff;
      run_in      = run_ff;
      rd_used_in  = cur_used;
      rd_addr_in  = addr_ff;
      rd_row_in   = row_ff;
      rd_slot_in  = slot_ff;
      ok_in       = ok_ff;
      res_row_in  = res_row_ff;
      res_slot_in = res_slot_ff;

      req_ready         = 1'b0;
      res_valid         = 1'b0;
      ram_req.wr_en     = 1'b0;
      ram_req.addr      = addr_ff;
      ram_req.wdata     = '{owner: tag_ff, run_len: len_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tag_in   = req_data.vehicle_tag;
               len_in   = req_data.vehicle_size;
               addr_in  = '0;
               row_in   = '0;
               slot_in  = '0;
               run_in   = '0;
               issue_in = 1'b1;
               if (req_data.req_type == ffsa_pkg::REQ_RELEASE) begin
                  state_in = ST_REL_SCAN;
               end else if (req_data.vehicle_size == '0 ||
                            ffsa_pkg::FREE_W'(req_data.vehicle_size) > free_ff ||
                            req_data.vehicle_size > ffsa_pkg::MAX_LEN) begin
                  ok_in       = 1'b0;
                  res_row_in  = '0;
                  res_slot_in = '0;
                  state_in    = ST_FINISH;
               end else begin
                  state_in = ST_ALLOC_SCAN;
               end
            end
         end

         ST_ALLOC_SCAN: begin
            if (run_nxt == len_ff) begin
               // run ends here: rewind to its first slot and fill it
               res_row_in  = row_ff;
               res_slot_in = slot_ff - ffsa_pkg::SLOT_W'(len_ff) + ffsa_pkg::SLOT_W'(1);
               addr_in     = addr_ff - ffsa_pkg::ADDR_W'(len_ff) + ffsa_pkg::ADDR_W'(1);
               run_in      = len_ff;
               state_in    = ST_ALLOC_WRITE;
            end else if (slot_ff == ffsa_pkg::LAST_SLOT) begin
               run_in = '0;
               if (row_ff == ffsa_pkg::LAST_ROW) begin
                  ok_in       = 1'b0;
                  res_row_in  = '0;
                  res_slot_in = '0;
                  state_in    = ST_FINISH;
               end else begin
                  row_in  = row_ff + ffsa_pkg::ROW_W'(1);
                  slot_in = '0;
                  addr_in = addr_ff + ffsa_pkg::ADDR_W'(1);
               end
            end else begin
               run_in  = run_nxt;
               slot_in = slot_ff + ffsa_pkg::SLOT_W'(1);
               addr_in = addr_ff + ffsa_pkg::ADDR_W'(1);
            end
         end

         ST_ALLOC_WRITE: begin
            ram_req.wr_en     = 1'b1;
            used_in[addr_ff]  = 1'b1;
            addr_in           = addr_ff + ffsa_pkg::ADDR_W'(1);
            run_in            = run_ff - ffsa_pkg::LEN_W'(1);
            if (run_ff == ffsa_pkg::LEN_W'(1)) begin
               free_in  = free_ff - ffsa_pkg::FREE_W'(len_ff);
               ok_in    = 1'b1;
               state_in = ST_FINISH;
            end
         end

         ST_REL_SCAN: begin
            // issue one read per cycle, compare the registered entry of the previous read
            rd_vld_in = issue_ff;
            if (issue_ff) begin
               addr_in = addr_ff + ffsa_pkg::ADDR_W'(1);
               if (slot_ff == ffsa_pkg::LAST_SLOT) begin
                  slot_in = '0;
                  if (row_ff == ffsa_pkg::LAST_ROW) begin
                     issue_in = 1'b0;
                  end else begin
                     row_in = row_ff + ffsa_pkg::ROW_W'(1);
                  end
               end else begin
                  slot_in = slot_ff + ffsa_pkg::SLOT_W'(1);
               end
            end
            if (rel_hit) begin
               rd_vld_in   = 1'b0;
               issue_in    = 1'b0;
               res_row_in  = rd_row_ff;
               res_slot_in = rd_slot_ff;
               addr_in     = rd_addr_ff;
               slot_in     = rd_slot_ff;
               run_in      = ram_rdata.run_len;
               state_in    = ST_REL_FREE;
            end else if (rd_vld_ff && rd_addr_ff == ffsa_pkg::LAST_ADDR) begin
               rd_vld_in   = 1'b0;
               ok_in       = 1'b0;
               res_row_in  = '0;
               res_slot_in = '0;
               state_in    = ST_FINISH;
            end
         end

         ST_REL_FREE: begin
            if (run_ff != '0 && cur_used) begin
               used_in[addr_ff] = 1'b0;
               free_in          = free_ff + ffsa_pkg::FREE_W'(1);
            end
            run_in  = run_ff - ffsa_pkg::LEN_W'(1);
            addr_in = addr_ff + ffsa_pkg::ADDR_W'(1);
            slot_in = slot_ff + ffsa_pkg::SLOT_W'(1);
            if (run_ff <= ffsa_pkg::LEN_W'(1) || slot_ff == ffsa_pkg::LAST_SLOT) begin
               ok_in    = 1'b1;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         used_ff   <= '0;
         free_ff   <= ffsa_pkg::FREE_RESET;
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         free_ff   <= free_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      len_ff      <= len_in;
      addr_ff     <= addr_in;
      row_ff      <= row_in;
      slot_ff     <= slot_in;
      run_ff      <= run_in;
      rd_used_ff  <= rd_used_in;
      rd_addr_ff  <= rd_addr_in;
      rd_row_ff   <= rd_row_in;
      rd_slot_ff  <= rd_slot_in;
      ok_ff       <= ok_in;
      res_row_ff  <= res_row_in;
      res_slot_ff <= res_slot_in;
   end

   assign res_data = '{ok: ok_ff, floor_index: res_row_ff,
                       slot_index: res_slot_ff, free_slots: free_ff};

endmodule

`default_nettype wire

/* hw/rtl/first_fit_slot_allocator_core.sv */
// First-fit slot allocator over a grid of 5 rows by 20 slots.
//
// Requests arrive on req_valid/req_ready/req_data: an allocate asks for a
// run of vehicle_size free slots inside one row and tags it; a release
// frees the run owned by the first used slot whose tag matches. Every
// request yields exactly one transfer on rsp_valid/rsp_ready/rsp_data with
// ok, the row and first slot of the run, and the free count afterwards.
// One request is worked at a time. An allocate walks the used flags one
// slot per cycle until the run fits and then writes one slot per cycle for
// the run length; a release reads the slot memory one entry per cycle until
// the tag matches and then frees one slot per cycle. The time to rsp_valid
// therefore depends on the scan length and the run length. Requests that
// fail the length check skip the scan and go straight to the finish state.
// A new request is taken the cycle after the result moves to the output
// register, so no new request is taken while an earlier one is in work.
// Reset clears all used flags and sets the free count to 100; no clearing
// pass is needed. A result waits in the output register while the receiver
// stalls, and the next request is still accepted in that time.
`default_nettype none

module first_fit_slot_allocator_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire ffsa_pkg::ffsa_req_type req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      ffsa_pkg::ffsa_rsp_type rsp_data
);

   ffsa_pkg::ffsa_ram_req_type ram_req;
   ffsa_pkg::ffsa_entry_type   ram_rdata;
   logic                       res_valid;
   logic                       res_ready;
   ffsa_pkg::ffsa_rsp_type     res_data;

   logic                       rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::ffsa_rsp_type     rsp_data_ff, rsp_data_in;

   ffsa_slot_ram u_slot_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

   ffsa_scan_ctrl u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_slots <= ffsa_pkg::FREE_RESET)
      else $error("free count above slot total");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.floor_index == '0 &&
                                       rsp_data.slot_index == '0))
      else $error("failed result carries a position");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ok) |-> (rsp_data.floor_index <= ffsa_pkg::LAST_ROW &&
                                      rsp_data.slot_index <= ffsa_pkg::LAST_SLOT))
      else $error("result position outside the grid");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");
`endif

endmodule

`default_nettype wire

/* tb/ffsa_result_checker.sv */
// Scoreboard for the first-fit slot allocator: tracks the slot grid from the
// accepted requests and compares every result transfer against it.
// Depends on ffsa_pkg for the payload structs and grid dimensions.

module ffsa_result_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire ffsa_pkg::ffsa_req_type req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire ffsa_pkg::ffsa_rsp_type rsp_data,
   output int                          n_errors,
   output int                          n_pending,
   output int                          n_checked,
   output int                          n_placed,
   output int                          n_freed
);
   timeunit 1ns;
   timeprecision 1ps;

   bit                            slot_busy [ffsa_pkg::TOTAL_SLOTS];
   logic [ffsa_pkg::TAG_BITS-1:0] slot_tag  [ffsa_pkg::TOTAL_SLOTS];
   logic [ffsa_pkg::LEN_W-1:0]    slot_len  [ffsa_pkg::TOTAL_SLOTS];
   int                            free_total;
   ffsa_pkg::ffsa_rsp_type        placement_q[$];

   // Apply one request to the grid copy and return the result it must give.
   function automatic ffsa_pkg::ffsa_rsp_type apply_request(
         input ffsa_pkg::ffsa_req_type rq);
      ffsa_pkg::ffsa_rsp_type res;
      int                     len;
      int                     p;
      int                     run;
      bit                     found;
      bit                     clear;
      res   = '0;
      found = 1'b0;
      len   = int'(rq.vehicle_size);
      if (rq.req_type == ffsa_pkg::REQ_ALLOC) begin
         if (len != 0 && len <= free_total && len <= ffsa_pkg::SLOTS_PER_ROW) begin
            for (int r = 0; r < ffsa_pkg::ROWS && !found; r++) begin
               for (int s = 0; s + len <= ffsa_pkg::SLOTS_PER_ROW && !found; s++) begin
                  clear = 1'b1;
                  for (int k = 0; k < len; k++) begin
                     if (slot_busy[r * ffsa_pkg::SLOTS_PER_ROW + s + k]) clear = 1'b0;
                  end
                  if (clear) begin
                     for (int k = 0; k < len; k++) begin
                        p = r * ffsa_pkg::SLOTS_PER_ROW + s + k;
                        slot_busy[p] = 1'b1;
                        slot_tag[p]  = rq.vehicle_tag;
                        slot_len[p]  = rq.vehicle_size;
                     end
                     free_total -= len;
                     found = 1'b1;
                     res.ok          = 1'b1;
                     res.floor_index = ffsa_pkg::ROW_W'(r);
                     res.slot_index  = ffsa_pkg::SLOT_W'(s);
                  end
               end
            end
         end
      end else begin
         for (int r = 0; r < ffsa_pkg::ROWS && !found; r++) begin
            for (int s = 0; s < ffsa_pkg::SLOTS_PER_ROW && !found; s++) begin
               p = r * ffsa_pkg::SLOTS_PER_ROW + s;
               if (slot_busy[p] && slot_tag[p] == rq.vehicle_tag) begin
                  run = int'(slot_len[p]);
                  // free only inside this row and only slots still in use
                  for (int k = 0; k < run && s + k < ffsa_pkg::SLOTS_PER_ROW; k++) begin
                     if (slot_busy[p + k]) begin
                        slot_busy[p + k] = 1'b0;
                        free_total++;
                     end
                  end
                  found = 1'b1;
                  res.ok          = 1'b1;
                  res.floor_index = ffsa_pkg::ROW_W'(r);
                  res.slot_index  = ffsa_pkg::SLOT_W'(s);
               end
            end
         end
      end
      res.free_slots = ffsa_pkg::FREE_W'(free_total);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      ffsa_pkg::ffsa_rsp_type want;
      ffsa_pkg::ffsa_rsp_type got;
      if (reset) begin
         for (int i = 0; i < ffsa_pkg::TOTAL_SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_len[i]  = '0;
         end
         free_total = ffsa_pkg::TOTAL_SLOTS;
         placement_q.delete();
         n_errors  = 0;
         n_checked = 0;
         n_placed  = 0;
         n_freed   = 0;
      end else begin
         if (req_valid && req_ready) begin
            want = apply_request(req_data);
            if (want.ok && req_data.req_type == ffsa_pkg::REQ_ALLOC) n_placed++;
            if (want.ok && req_data.req_type == ffsa_pkg::REQ_RELEASE) n_freed++;
            // append at the tail, results leave from the head
            placement_q = {placement_q, want};
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (placement_q.size() == 0) begin
               if (n_errors < 10)
                  $display("%0t: result with none outstanding: ok=%0d row=%0d slot=%0d",
                           $realtime, got.ok, got.floor_index, got.slot_index,
                           " free=%0d", got.free_slots);
               n_errors++;
            end else begin
               want = placement_q.pop_front();
               n_checked++;
               if (got.ok !== want.ok || got.floor_index !== want.floor_index ||
                   got.slot_index !== want.slot_index ||
                   got.free_slots !== want.free_slots) begin
                  if (n_errors < 10) begin
                     $display("%0t: mismatch exp ok=%0d row=%0d slot=%0d free=%0d,",
                              $realtime, want.ok, want.floor_index, want.slot_index,
                              want.free_slots);
                     $display("   got ok=%0d row=%0d slot=%0d free=%0d",
                              got.ok, got.floor_index, got.slot_index, got.free_slots);
                  end
                  n_errors++;
               end
            end
         end
      end
      n_pending = placement_q.size();
   end

endmodule

/* tb/tb_first_fit_slot_allocator_core.sv */
// Top of the first-fit slot allocator testbench: clock, reset, request and
// result-side traffic, watchdog and verdict. Depends on ffsa_pkg, the core
// and ffsa_result_checker.

module tb_first_fit_slot_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 150;
   localparam int TAG_POOL     = 16;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   ffsa_pkg::ffsa_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   ffsa_pkg::ffsa_rsp_type rsp_data;

   int n_errors;
   int n_pending;
   int n_checked;
   int n_placed;
   int n_freed;
   int n_alloc_sent   = 0;
   int n_release_sent = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;
   bit hold_rsp_now   = 1'b0;

   logic [ffsa_pkg::TAG_BITS-1:0] tag_pool [TAG_POOL];

   first_fit_slot_allocator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ffsa_result_checker result_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .n_errors  (n_errors),
      .n_pending (n_pending),
      .n_checked (n_checked),
      .n_placed  (n_placed),
      .n_freed   (n_freed)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [ffsa_pkg::TAG_BITS-1:0] random_tag();
      return ffsa_pkg::TAG_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic ffsa_pkg::ffsa_req_type make_req(
         input logic                          kind,
         input logic [ffsa_pkg::TAG_BITS-1:0] tag,
         input logic [ffsa_pkg::LEN_W-1:0]    size);
      ffsa_pkg::ffsa_req_type rq;
      rq.req_type     = kind;
      rq.vehicle_tag  = tag;
      rq.vehicle_size = size;
      return rq;
   endfunction

   // Present one request at the falling edge, hold it until the transfer,
   // then either keep valid high for the next one or open a gap.
   task automatic offer(input ffsa_pkg::ffsa_req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.req_type == ffsa_pkg::REQ_ALLOC) n_alloc_sent++;
      else n_release_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(negedge clock);
         burst_left = $urandom_range(0, 40);
      end else begin
         burst_left--;
      end
   endtask

   // Result side: segments of always-ready, coin-flip, mostly-stalled and
   // mostly-ready, plus one long hold-off when the stimulus asks for it.
   initial begin : rsp_side
      int seg_left;
      int mode;
      int hold_left;
      seg_left  = 0;
      mode      = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp_now) begin
            hold_rsp_now = 1'b0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, n_pending);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                            pick;
      logic [ffsa_pkg::LEN_W-1:0]    size;
      logic [ffsa_pkg::TAG_BITS-1:0] stray;
      tag_pool[0] = '1;
      tag_pool[1] = '0;
      for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = random_tag();
      stray = random_tag();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: failure paths, filling the grid, first-fit reuse
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[1], 5'd0));   // nothing to release yet
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[2], 5'd0));   // zero length
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[2], 5'd31));  // longer than a row
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[2], 5'd21));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[0], ffsa_pkg::MAX_LEN));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[1], 5'd1));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[2], 5'd19));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[3], ffsa_pkg::MAX_LEN));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[4], ffsa_pkg::MAX_LEN));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[5], 5'd10));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[6], 5'd11));  // above the free count
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[6], 5'd10));  // grid now full
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[7], 5'd1));
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[0], 5'd31));  // size ignored on release
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[1], 5'd0));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[7], 5'd1));
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[8], 5'd2));
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[2], 5'd0));
      offer(make_req(ffsa_pkg::REQ_RELEASE, stray,       5'd7));   // no owner matches
      offer(make_req(ffsa_pkg::REQ_ALLOC,   tag_pool[9], 5'd16));
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[3], 5'd0));
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[4], 5'd0));
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[5], 5'd0));
      offer(make_req(ffsa_pkg::REQ_RELEASE, tag_pool[6], 5'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_rsp_now = 1'b1;
         if (n == 600) begin
            // let the block drain completely before going on
            req_valid <= 1'b0;
            wait (n_pending == 0);
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            size = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(21, 31));
            offer(make_req(ffsa_pkg::REQ_ALLOC, random_tag(), size));
         end else if (pick < 58) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) size = 5'($urandom_range(1, 6));
            else if (pick < 95) size = 5'($urandom_range(7, 14));
            else size = 5'($urandom_range(15, 20));
            offer(make_req(ffsa_pkg::REQ_ALLOC,
                           tag_pool[$urandom_range(0, TAG_POOL - 1)], size));
         end else if (pick < 95) begin
            offer(make_req(ffsa_pkg::REQ_RELEASE,
                           tag_pool[$urandom_range(0, TAG_POOL - 1)],
                           5'($urandom_range(0, 31))));
         end else begin
            offer(make_req(ffsa_pkg::REQ_RELEASE, random_tag(),
                           5'($urandom_range(0, 31))));
         end
      end

      req_valid <= 1'b0;
      wait (n_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d allocate, %0d release), %0d results checked",
               n_alloc_sent + n_release_sent, n_alloc_sent, n_release_sent, n_checked);
      $display("Runs placed %0d, runs freed %0d, mismatches %0d, outstanding %0d",
               n_placed, n_freed, n_errors, n_pending);
      if (n_errors == 0 && n_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_slot_ram.sv
hw/rtl/ffsa_scan_ctrl.sv
hw/rtl/first_fit_slot_allocator_core.sv
tb/ffsa_result_checker.sv
tb/tb_first_fit_slot_allocator_core.sv
